>>> rtl/core/mdbcr_pkg.sv
// ----------------------------------------------------------------------------
// mdbcr_pkg
// Shared constants and types of the cashless frame responder.
// ----------------------------------------------------------------------------
package mdbcr_pkg;

    localparam int FRAME_DEPTH = 36;
    localparam int FL_W        = 6;
    localparam int FA_W        = $clog2(FRAME_DEPTH);

    // input event codes
    localparam logic [2:0] EV_WORD    = 3'd0;
    localparam logic [2:0] EV_TIMEOUT = 3'd1;
    localparam logic [2:0] EV_CARD_IN = 3'd2;
    localparam logic [2:0] EV_CARD_RM = 3'd3;
    localparam logic [2:0] EV_RESET   = 3'd4;

    // reader states
    localparam logic [2:0] RDR_INACTIVE = 3'd0;
    localparam logic [2:0] RDR_DISABLED = 3'd1;
    localparam logic [2:0] RDR_ENABLED  = 3'd2;
    localparam logic [2:0] RDR_SESSION  = 3'd3;
    localparam logic [2:0] RDR_VEND     = 3'd4;

    localparam logic [4:0] CASHLESS_ADDR = 5'h02;  // 0x10 >> 3

    // commands (low three bits of the mode word)
    localparam logic [2:0] OP_RESET  = 3'd0;
    localparam logic [2:0] OP_SETUP  = 3'd1;
    localparam logic [2:0] OP_POLL   = 3'd2;
    localparam logic [2:0] OP_VEND   = 3'd3;
    localparam logic [2:0] OP_READER = 3'd4;
    localparam logic [2:0] OP_EXP    = 3'd7;

    // subcommands
    localparam logic [7:0] SC_CFG         = 8'h00;
    localparam logic [7:0] SC_PRICES      = 8'h01;
    localparam logic [7:0] SC_VEND_REQ    = 8'h00;
    localparam logic [7:0] SC_VEND_CANCEL = 8'h01;
    localparam logic [7:0] SC_VEND_OK     = 8'h02;
    localparam logic [7:0] SC_VEND_FAIL   = 8'h03;
    localparam logic [7:0] SC_SESS_DONE   = 8'h04;
    localparam logic [7:0] SC_CASH_SALE   = 8'h05;
    localparam logic [7:0] SC_RDR_DIS     = 8'h00;
    localparam logic [7:0] SC_RDR_EN      = 8'h01;
    localparam logic [7:0] SC_RDR_CANCEL  = 8'h02;
    localparam logic [7:0] SC_PID         = 8'h00;

    // response codes
    localparam logic [7:0] RC_ACK        = 8'h00;
    localparam logic [7:0] RC_NAK        = 8'hFF;
    localparam logic [7:0] RC_JUST_RESET = 8'h00;
    localparam logic [7:0] RC_BEGIN      = 8'h03;
    localparam logic [7:0] RC_APPROVED   = 8'h05;
    localparam logic [7:0] RC_DENIED     = 8'h06;
    localparam logic [7:0] RC_END        = 8'h07;
    localparam logic [7:0] RC_CANCELLED  = 8'h08;
    localparam logic [7:0] RC_PID        = 8'h09;

    // register indexes
    localparam logic [2:0] RG_ACK   = 3'd0;
    localparam logic [2:0] RG_MFG   = 3'd1;
    localparam logic [2:0] RG_SERH  = 3'd2;
    localparam logic [2:0] RG_SERL  = 3'd3;
    localparam logic [2:0] RG_MODH  = 3'd4;
    localparam logic [2:0] RG_MODL  = 3'd5;
    localparam logic [2:0] RG_SWVER = 3'd6;

    // response kinds
    typedef enum logic [2:0] {
        RK_NONE, RK_ACK, RK_NAK, RK_ONE, RK_SHORT, RK_CFG, RK_PID
    } t_resp;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EVAL, S_OUT
    } t_state;

    localparam logic [7:0] RDR_CFG [8] = '{8'h01, 8'h01, 8'h00, 8'h07,
                                           8'h01, 8'h02, 8'h05, 8'h00};

endpackage

>>> rtl/core/mdb_cashless_frame_responder.sv
// ----------------------------------------------------------------------------
// mdb_cashless_frame_responder
// Frame assembly, sum check and command dispatch for cashless address 0x10.
// ----------------------------------------------------------------------------
// Flow: a stored data word starts a sum check that reads the frame store back
//   (one frame-store read per cycle), then a response streams out at one word
//   per cycle while m_axis_tready is high. Host events are handled in S_IDLE.
// Requests: one at a time; taken only in S_IDLE with no output word waiting.
// Reset: synchronous, active low; clears control state. Frame store is not
//   cleared (entries beyond frame_length are never read).
module mdb_cashless_frame_responder
    import mdbcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [7:0] word_byte, [8] word_ninth, [24:9] card_amount, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // tuser: [2:0] mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [7:0] tx_byte, [8] tx_ninth, [11:9] reader_state, [15:12] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // configuration registers
    logic        r_ack;
    logic [23:0] r_mfg;
    logic [63:0] r_serh, r_modh;
    logic [31:0] r_serl, r_modl;
    logic [15:0] r_swver;
    logic [2:0]  w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack <= 1'b1; r_mfg <= 24'h202020;
            r_serh <= 64'h2020202020202020; r_serl <= 32'h20202020;
            r_modh <= 64'h2020202020202020; r_modl <= 32'h20202020;
            r_swver <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_ridx)
                RG_ACK:   r_ack   <= pwdata[0];
                RG_MFG:   r_mfg   <= pwdata[23:0];
                RG_SERH:  r_serh  <= pwdata;
                RG_SERL:  r_serl  <= pwdata[31:0];
                RG_MODH:  r_modh  <= pwdata;
                RG_MODL:  r_modl  <= pwdata[31:0];
                RG_SWVER: r_swver <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            RG_ACK:   prdata = {63'd0, r_ack};
            RG_MFG:   prdata = {40'd0, r_mfg};
            RG_SERH:  prdata = r_serh;
            RG_SERL:  prdata = {32'd0, r_serl};
            RG_MODH:  prdata = r_modh;
            RG_MODL:  prdata = {32'd0, r_modl};
            RG_SWVER: prdata = {48'd0, r_swver};
            default:  prdata = '0;
        endcase
    end

    // frame store
    logic [7:0]  mem [FRAME_DEPTH];
    logic        w_we;
    logic [FA_W-1:0] w_waddr, w_raddr;
    logic [7:0]  w_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // control state
    t_state      r_st, n_st;
    logic [2:0]  r_cst, n_cst;
    logic        r_rp, n_rp, r_card, n_card;
    logic [15:0] r_bal, n_bal;
    logic [FL_W-1:0] r_len, n_len;
    // latched request
    logic [7:0]  r_byte;
    logic        r_ninth;
    logic [2:0]  r_mode;
    // scan
    logic [FL_W-1:0] r_len_s, n_len_s;   // frame length being checked
    logic [FL_W-1:0] r_idx, n_idx;       // next address requested
    logic [FL_W-1:0] r_cnt, n_cnt;       // bytes consumed
    logic [7:0]  r_sum, n_sum, r_lastb, n_lastb;
    logic [7:0]  r_b0, n_b0, r_b1, n_b1, r_b2, n_b2, r_b3, n_b3;
    logic        r_rv, n_rv;             // read data valid next cycle
    logic        r_open, n_open;         // reopen with r_byte after dispatch
    logic        r_force, n_force;       // dispatch even if one byte
    // output
    t_resp       r_rk, n_rk;
    logic [7:0]  r_code, n_code, r_osum, n_osum;
    logic [15:0] r_val, n_val;
    logic [4:0]  r_oi, n_oi;
    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    logic        r_on, n_on, r_ol, n_ol;

    logic        w_acc, w_oacc, w_word_go;
    logic [7:0]  w_pl, w_ob;
    logic [4:0]  w_plen;
    logic        w_isdata, w_on;

    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_oacc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_cst, r_on, r_ob};
    assign m_axis_tlast  = r_ol;

    // payload byte for current response index
    always_comb begin
        w_pl = 8'h00;
        w_plen = 5'd1;
        case (r_rk)
            RK_ONE: begin w_pl = r_code; w_plen = 5'd1; end
            RK_SHORT: begin
                w_plen = 5'd3;
                case (r_oi)
                    5'd0: w_pl = r_code;
                    5'd1: w_pl = r_val[15:8];
                    default: w_pl = r_val[7:0];
                endcase
            end
            RK_CFG: begin w_plen = 5'd8; w_pl = RDR_CFG[r_oi[2:0]]; end
            RK_PID: begin
                w_plen = 5'd30;
                if (r_oi == 5'd0) w_pl = RC_PID;
                else if (r_oi < 5'd4) w_pl = r_mfg[8*(3-r_oi) +: 8];
                else if (r_oi < 5'd12) w_pl = r_serh[8*(11-r_oi) +: 8];
                else if (r_oi < 5'd16) w_pl = r_serl[8*(15-r_oi) +: 8];
                else if (r_oi < 5'd24) w_pl = r_modh[8*(23-r_oi) +: 8];
                else if (r_oi < 5'd28) w_pl = r_modl[8*(27-r_oi) +: 8];
                else if (r_oi == 5'd28) w_pl = r_swver[15:8];
                else w_pl = r_swver[7:0];
            end
            default: ;
        endcase
        w_isdata = (r_oi < w_plen);
        w_ob = w_isdata ? w_pl : r_osum;
        w_on = !w_isdata;
    end

    assign w_word_go = (r_mode == EV_WORD);

    always_comb begin
        logic [2:0] cmd;
        logic [7:0] sub;
        logic       lge2, ok;
        logic [15:0] price;
        n_st = r_st; n_cst = r_cst; n_rp = r_rp; n_card = r_card; n_bal = r_bal;
        n_len = r_len; n_len_s = r_len_s; n_idx = r_idx; n_cnt = r_cnt;
        n_sum = r_sum; n_lastb = r_lastb; n_rv = 1'b0;
        n_b0 = r_b0; n_b1 = r_b1; n_b2 = r_b2; n_b3 = r_b3;
        n_open = r_open; n_force = r_force;
        n_rk = r_rk; n_code = r_code; n_val = r_val; n_osum = r_osum; n_oi = r_oi;
        n_ov = r_ov; n_ob = r_ob; n_on = r_on; n_ol = r_ol;
        w_we = 1'b0; w_waddr = '0; w_wdata = r_byte; w_raddr = r_idx[FA_W-1:0];
        cmd = r_b0[2:0]; sub = (r_len_s >= 2) ? r_b1 : 8'h00;
        lge2 = (r_len_s >= 2); price = {r_b2, r_b3};
        ok = 1'b0;
        if (w_oacc) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_open = 1'b0; n_force = 1'b0;
                    n_len_s = r_len; n_idx = '0; n_cnt = '0; n_sum = '0;
                    case (s_axis_tuser)
                        EV_WORD: begin
                            if (s_axis_tdata[8]) begin
                                n_open = (s_axis_tdata[7:3] == CASHLESS_ADDR);
                                n_force = 1'b1;
                                if (r_len != '0) n_st = S_SCAN;
                                else if (n_open) begin
                                    w_we = 1'b1; w_waddr = '0;
                                    w_wdata = s_axis_tdata[7:0]; n_len = 6'd1;
                                end
                            end else if (r_len != '0) begin
                                if (r_len < FL_W'(FRAME_DEPTH)) begin
                                    w_we = 1'b1; w_waddr = r_len[FA_W-1:0];
                                    w_wdata = s_axis_tdata[7:0];
                                    n_len = r_len + 1'b1; n_len_s = r_len + 1'b1;
                                    n_st = S_SCAN;
                                end else n_len = '0;
                            end
                        end
                        EV_TIMEOUT: begin
                            if (r_len >= 2) n_st = S_SCAN;
                            n_len = '0;
                        end
                        EV_CARD_IN: begin n_bal = s_axis_tdata[24:9]; n_card = 1'b1; end
                        EV_CARD_RM: begin n_bal = '0; n_card = 1'b0; end
                        EV_RESET: begin
                            n_cst = RDR_INACTIVE; n_rp = 1'b1; n_card = 1'b0; n_bal = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // stream frame bytes: sum all but last
            S_SCAN: begin
                if (r_idx < r_len_s) begin
                    w_raddr = r_idx[FA_W-1:0];
                    n_idx = r_idx + 1'b1;
                    n_rv = 1'b1;
                end
                if (r_rv) begin
                    case (r_cnt)
                        6'd0: n_b0 = r_rdata;
                        6'd1: n_b1 = r_rdata;
                        6'd2: n_b2 = r_rdata;
                        6'd3: n_b3 = r_rdata;
                        default: ;
                    endcase
                    if (r_cnt + 1'b1 == r_len_s) n_lastb = r_rdata;
                    else n_sum = r_sum + r_rdata;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == r_len_s) n_st = S_EVAL;
                end
            end
            S_EVAL: begin
                n_st = S_IDLE;
                n_rk = RK_NONE; n_oi = '0; n_osum = '0;
                if (lge2) ok = (r_sum == r_lastb);
                else ok = r_force;
                if (w_word_go && !r_ninth && !ok) begin
                    ok = 1'b0;  // pending frame continues
                end else if (w_word_go && !r_ninth) begin
                    n_len = '0;
                end else if (w_word_go && r_ninth) begin
                    if (r_open) begin
                        w_we = 1'b1; w_waddr = '0; w_wdata = r_byte; n_len = 6'd1;
                    end else n_len = '0;
                end
                if (ok) begin
                    case (cmd)
                        OP_RESET: begin n_cst = RDR_INACTIVE; n_rp = 1'b1; n_rk = RK_ACK; end
                        OP_SETUP: begin
                            if (!lge2) n_rk = RK_NAK;
                            else if (sub == SC_CFG) begin
                                n_rk = RK_CFG;
                                if (r_cst == RDR_INACTIVE) n_cst = RDR_DISABLED;
                            end else if (sub == SC_PRICES) n_rk = RK_ACK;
                            else n_rk = RK_NAK;
                        end
                        OP_POLL: begin
                            if (r_rp) begin
                                n_rk = RK_ONE; n_code = RC_JUST_RESET; n_rp = 1'b0;
                            end else if (r_cst == RDR_ENABLED && r_card) begin
                                n_rk = RK_SHORT; n_code = RC_BEGIN; n_val = r_bal;
                                n_cst = RDR_SESSION;
                            end else n_rk = RK_ACK;
                        end
                        OP_VEND: begin
                            if (!lge2) n_rk = RK_NAK;
                            else if (sub == SC_VEND_REQ && r_len_s >= 7) begin
                                if (r_cst != RDR_SESSION || price > r_bal) begin
                                    n_rk = RK_ONE; n_code = RC_DENIED;
                                end else begin
                                    n_bal = r_bal - price; n_rk = RK_SHORT;
                                    n_code = RC_APPROVED; n_val = price; n_cst = RDR_VEND;
                                end
                            end else if (sub == SC_VEND_CANCEL) begin
                                n_rk = RK_ONE; n_code = RC_DENIED;
                            end else if (sub == SC_VEND_OK || sub == SC_VEND_FAIL) begin
                                n_rk = RK_ACK; n_cst = RDR_SESSION;
                            end else if (sub == SC_SESS_DONE) begin
                                n_rk = RK_ONE; n_code = RC_END; n_card = 1'b0;
                                n_cst = RDR_ENABLED;
                            end else if (sub == SC_CASH_SALE) n_rk = RK_ACK;
                            else n_rk = RK_NAK;
                        end
                        OP_READER: begin
                            if (!lge2) n_rk = RK_NAK;
                            else if (sub == SC_RDR_DIS) begin
                                n_rk = RK_ACK;
                                if (r_cst == RDR_ENABLED || r_cst == RDR_SESSION)
                                    n_cst = RDR_DISABLED;
                            end else if (sub == SC_RDR_EN) begin
                                n_rk = RK_ACK;
                                if (r_cst == RDR_DISABLED) n_cst = RDR_ENABLED;
                            end else if (sub == SC_RDR_CANCEL) begin
                                n_rk = RK_ONE; n_code = RC_CANCELLED;
                            end else n_rk = RK_NAK;
                        end
                        OP_EXP: n_rk = (lge2 && sub == SC_PID) ? RK_PID : RK_ACK;
                        default: n_rk = RK_NAK;
                    endcase
                    if (n_rk != RK_NONE) n_st = S_OUT;
                end
            end
            // one response word per cycle through the output register, when it is free or taken
            S_OUT: begin
                if (!r_ov || w_oacc) begin
                    n_ov = 1'b1;
                    if (r_rk == RK_ACK) begin
                        n_ob = RC_ACK; n_on = r_ack; n_ol = 1'b1; n_st = S_IDLE;
                    end else if (r_rk == RK_NAK) begin
                        n_ob = RC_NAK; n_on = 1'b1; n_ol = 1'b1; n_st = S_IDLE;
                    end else begin
                        n_ob = w_ob; n_on = w_on; n_ol = w_on;
                        n_osum = r_osum + w_pl;
                        n_oi = r_oi + 1'b1;
                        if (w_on) n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cst <= RDR_INACTIVE; r_rp <= 1'b0; r_card <= 1'b0;
            r_bal <= '0; r_len <= '0; r_rv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cst <= n_cst; r_rp <= n_rp; r_card <= n_card;
            r_bal <= n_bal; r_len <= n_len; r_rv <= n_rv; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byte <= s_axis_tdata[7:0]; r_ninth <= s_axis_tdata[8]; r_mode <= s_axis_tuser;
        end
        r_len_s <= n_len_s; r_idx <= n_idx; r_cnt <= n_cnt; r_sum <= n_sum;
        r_lastb <= n_lastb; r_b0 <= n_b0; r_b1 <= n_b1; r_b2 <= n_b2; r_b3 <= n_b3;
        r_open <= n_open; r_force <= n_force; r_rk <= n_rk; r_code <= n_code;
        r_val <= n_val; r_osum <= n_osum; r_oi <= n_oi; r_ob <= n_ob;
        r_on <= n_on; r_ol <= n_ol;
    end

endmodule

>>> rtl/core/mdbcr_checker.sv
// ----------------------------------------------------------------------------
// mdbcr_checker
// Port-level checks on the cashless frame responder.
// ----------------------------------------------------------------------------
module mdbcr_checker
    import mdbcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // no new request taken while a response word waits
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
    // reader state field never out of range
    a_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:9] <= RDR_VEND)) else $error("bad state");
    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    // word with ninth bit clear and a nonzero byte is never the last one
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[8] && m_axis_tdata[7:0] != 8'h00 |-> !m_axis_tlast)
        else $error("data word marked last");
endmodule

bind mdb_cashless_frame_responder mdbcr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast));
